[src/rscv_pkg.sv]
package rscv_pkg;

   localparam int POS_W = 20;
   localparam int D_W = 21;
   localparam int CFG_W = 12;
   localparam int IDX_W = 1;
   localparam int FRAC_BITS_DEF = 8;

   localparam logic [CFG_W-1:0] VIEW_WIDTH_RST = 12'd1920;
   localparam logic [CFG_W-1:0] VIEW_HEIGHT_RST = 12'd1080;

   localparam logic [IDX_W-1:0] REG_VIEW_WIDTH = 1'b0;
   localparam logic [IDX_W-1:0] REG_VIEW_HEIGHT = 1'b1;

   localparam logic OP_STEP = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // quotient of the scaled step stays below 2**D_W, one bit per step
   localparam int DIV_STEPS = D_W;
   localparam int CNT_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic capture;
      logic calc;
      logic prod;
      logic sel;
      logic mul;
      logic div_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic is_load;
      logic skip;
      logic viol;
   } sts_type;

endpackage

[src/rscv_ctrl.sv]
module rscv_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  rscv_pkg::sts_type  sts,
   output rscv_pkg::cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CALC = 3'd1;
   localparam logic [2:0] ST_PROD = 3'd2;
   localparam logic [2:0] ST_SEL  = 3'd3;
   localparam logic [2:0] ST_MUL  = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_FIN  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [rscv_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic out_valid_ff, out_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            if (sts.is_load || sts.skip || !sts.viol) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            cmd.prod = 1'b1;
            state_in = ST_SEL;
         end
         ST_SEL: begin
            cmd.sel = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            cnt_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == rscv_pkg::CNT_W'(rscv_pkg::DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // point registers double as the output register
            if (!out_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_valid_in = cmd.commit | (out_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

[src/rscv_dp.sv]
module rscv_dp #(
   parameter int FRAC_BITS = rscv_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rscv_pkg::cmd_type                     cmd,
   output rscv_pkg::sts_type                     sts,
   input  logic                                  req_op,
   input  logic signed [rscv_pkg::D_W-1:0]       req_step_dx,
   input  logic signed [rscv_pkg::D_W-1:0]       req_step_dy,
   input  logic [rscv_pkg::POS_W-1:0]            req_load_x,
   input  logic [rscv_pkg::POS_W-1:0]            req_load_y,
   input  logic                                  csr_wen,
   input  logic [rscv_pkg::IDX_W-1:0]            csr_index,
   input  logic [rscv_pkg::CFG_W-1:0]            csr_wdata,
   output logic [rscv_pkg::POS_W-1:0]            rsp_pos_x,
   output logic [rscv_pkg::POS_W-1:0]            rsp_pos_y,
   output logic                                  rsp_at_edge
);

   localparam int PW = rscv_pkg::POS_W;
   localparam int DW = rscv_pkg::D_W;
   localparam int SW = PW + 3;
   localparam int MW = PW + DW;
   localparam int BW = rscv_pkg::CFG_W + FRAC_BITS;
   localparam int EW = (BW > PW) ? BW : PW;
   localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

   typedef struct packed {
      logic          viol;
      logic [PW-1:0] edge_pos;
      logic [PW-1:0] num;
      logic [DW-1:0] den;
   } frac_type;

   function automatic logic [PW-1:0] sat_pos(input logic signed [SW-1:0] v);
      logic [PW-1:0] r;
      if (v[SW-1]) begin
         r = '0;
      end else if (v > $signed({3'b000, POS_MAX})) begin
         r = POS_MAX;
      end else begin
         r = v[PW-1:0];
      end
      return r;
   endfunction

   function automatic logic [PW-1:0] bound_of(input logic [rscv_pkg::CFG_W-1:0] pix);
      logic [EW-1:0] b;
      logic [PW-1:0] r;
      b = EW'(pix) << FRAC_BITS;
      if (b > EW'(POS_MAX)) begin
         r = POS_MAX;
      end else begin
         r = b[PW-1:0];
      end
      return r;
   endfunction

   function automatic frac_type edge_frac(input logic [PW-1:0] p,
                                          input logic signed [DW-1:0] d,
                                          input logic [PW-1:0] bound);
      logic signed [SW-1:0] n;
      logic over;
      frac_type f;
      n = $signed({3'b000, p}) + $signed({{2{d[DW-1]}}, d});
      over = !n[SW-1] && (n > $signed({3'b000, bound}));
      f.viol = n[SW-1] | over;
      f.edge_pos = n[SW-1] ? '0 : bound;
      f.num = PW'(1);
      f.den = DW'(1);
      if (n[SW-1]) begin
         f.num = p;
         f.den = DW'(-d);
      end else if (over) begin
         // already past the far edge, or moving away: snap with zero fraction
         if (p > bound || d[DW-1] || d == '0) begin
            f.num = '0;
            f.den = DW'(1);
         end else begin
            f.num = bound - p;
            f.den = d;
         end
      end
      return f;
   endfunction

   logic [rscv_pkg::CFG_W-1:0] view_width_ff, view_height_ff;
   logic [PW-1:0] point_x_ff, point_y_ff, point_x_in, point_y_in;
   logic edge_ff, edge_in;

   logic op_ff;
   logic signed [DW-1:0] dx_ff, dy_ff;
   logic [PW-1:0] lx_ff, ly_ff;

   logic viol_ff, vx_ff, vy_ff;
   logic [PW-1:0] ex_ff, ey_ff, nx_ff, ny_ff;
   logic [DW-1:0] dnx_ff, dny_ff;
   logic [MW-1:0] p1_ff, p2_ff;
   logic choose_x_ff;
   logic neg_ff;
   logic [DW-1:0] rem_ff, quo_ff;

   frac_type fx, fy;
   logic signed [DW-1:0] d_other;
   logic [DW-1:0] d_mag;
   logic [PW-1:0] num_sel;
   logic [DW-1:0] den_sel;
   logic [MW-1:0] scaled;
   logic [DW:0] trial;
   logic ge;
   logic signed [DW:0] q_s;
   logic signed [SW-1:0] sum_x, sum_y, clip_y, clip_x;

   assign fx = edge_frac(point_x_ff, dx_ff, bound_of(view_width_ff));
   assign fy = edge_frac(point_y_ff, dy_ff, bound_of(view_height_ff));

   assign sts.is_load = (op_ff == rscv_pkg::OP_LOAD);
   assign sts.skip = (op_ff == rscv_pkg::OP_STEP) && edge_ff;
   assign sts.viol = fx.viol | fy.viol;

   // scale the displacement of the axis that is not clipped
   assign d_other = choose_x_ff ? dy_ff : dx_ff;
   assign d_mag = d_other[DW-1] ? DW'(-d_other) : d_other;
   assign num_sel = choose_x_ff ? nx_ff : ny_ff;
   assign den_sel = choose_x_ff ? dnx_ff : dny_ff;
   assign scaled = MW'(d_mag) * MW'(num_sel);

   // restoring division, remainder stays below the divisor
   assign trial = {rem_ff, quo_ff[DW-1]};
   assign ge = (trial >= {1'b0, den_sel});

   assign q_s = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign sum_x = $signed({3'b000, point_x_ff}) + $signed({{2{dx_ff[DW-1]}}, dx_ff});
   assign sum_y = $signed({3'b000, point_y_ff}) + $signed({{2{dy_ff[DW-1]}}, dy_ff});
   assign clip_y = $signed({3'b000, point_y_ff}) + $signed({q_s[DW], q_s});
   assign clip_x = $signed({3'b000, point_x_ff}) + $signed({q_s[DW], q_s});

   always_comb begin
      point_x_in = point_x_ff;
      point_y_in = point_y_ff;
      edge_in = edge_ff;
      if (op_ff == rscv_pkg::OP_LOAD) begin
         point_x_in = lx_ff;
         point_y_in = ly_ff;
         edge_in = 1'b0;
      end else if (!edge_ff) begin
         if (!viol_ff) begin
            point_x_in = sat_pos(sum_x);
            point_y_in = sat_pos(sum_y);
         end else if (choose_x_ff) begin
            point_x_in = ex_ff;
            point_y_in = sat_pos(clip_y);
            edge_in = 1'b1;
         end else begin
            point_y_in = ey_ff;
            point_x_in = sat_pos(clip_x);
            edge_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         view_width_ff <= rscv_pkg::VIEW_WIDTH_RST;
         view_height_ff <= rscv_pkg::VIEW_HEIGHT_RST;
         point_x_ff <= '0;
         point_y_ff <= '0;
         edge_ff <= 1'b0;
      end else begin
         if (csr_wen && csr_index == rscv_pkg::REG_VIEW_WIDTH) begin
            view_width_ff <= csr_wdata;
         end
         if (csr_wen && csr_index == rscv_pkg::REG_VIEW_HEIGHT) begin
            view_height_ff <= csr_wdata;
         end
         if (cmd.commit) begin
            point_x_ff <= point_x_in;
            point_y_ff <= point_y_in;
            edge_ff <= edge_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_op;
         dx_ff <= req_step_dx;
         dy_ff <= req_step_dy;
         lx_ff <= req_load_x;
         ly_ff <= req_load_y;
      end
      if (cmd.calc) begin
         viol_ff <= fx.viol | fy.viol;
         vx_ff <= fx.viol;
         vy_ff <= fy.viol;
         ex_ff <= fx.edge_pos;
         ey_ff <= fy.edge_pos;
         nx_ff <= fx.num;
         ny_ff <= fy.num;
         dnx_ff <= fx.den;
         dny_ff <= fy.den;
      end
      if (cmd.prod) begin
         p1_ff <= MW'(nx_ff) * MW'(dny_ff);
         p2_ff <= MW'(ny_ff) * MW'(dnx_ff);
      end
      if (cmd.sel) begin
         // x edge wins a tie
         choose_x_ff <= vx_ff && (!vy_ff || p1_ff <= p2_ff);
      end
      if (cmd.mul) begin
         neg_ff <= d_other[DW-1];
         rem_ff <= DW'(scaled[MW-1:DW]);
         quo_ff <= scaled[DW-1:0];
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? DW'(trial - {1'b0, den_sel}) : trial[DW-1:0];
         quo_ff <= {quo_ff[DW-2:0], ge};
      end
   end

   assign rsp_pos_x = point_x_ff;
   assign rsp_pos_y = point_y_ff;
   assign rsp_at_edge = edge_ff;

endmodule

[src/ray_step_clip_to_viewport_top.sv]
// Ray step clipped to a viewport. Each transfer on req_ either loads a
// position (clearing the edge flag) or steps the point by a signed
// displacement in 1/2**FRAC_BITS pixel units, clipping at the rectangle set
// by the view_width/view_height CSRs. One rsp_ transfer follows every
// request, carrying the position and edge flag after that item. Items are
// handled one at a time: loads, steps that stay inside and steps while the
// flag is set go from the capture through CALC to FIN; a step that clips
// also passes PROD, SEL, MUL and the 21-step restoring divider that scales
// the other coordinate. A new request is taken while the previous result
// still waits on rsp_ready.
module ray_step_clip_to_viewport_top #(
   parameter int FRAC_BITS = rscv_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_op,
   input  logic signed [rscv_pkg::D_W-1:0]   req_step_dx,
   input  logic signed [rscv_pkg::D_W-1:0]   req_step_dy,
   input  logic [rscv_pkg::POS_W-1:0]        req_load_x,
   input  logic [rscv_pkg::POS_W-1:0]        req_load_y,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rscv_pkg::POS_W-1:0]        rsp_pos_x,
   output logic [rscv_pkg::POS_W-1:0]        rsp_pos_y,
   output logic                              rsp_at_edge,
   input  logic                              csr_wen,
   input  logic [rscv_pkg::IDX_W-1:0]        csr_index,
   input  logic [rscv_pkg::CFG_W-1:0]        csr_wdata
);

   rscv_pkg::cmd_type cmd;
   rscv_pkg::sts_type sts;

   rscv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rscv_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_op      (req_op),
      .req_step_dx (req_step_dx),
      .req_step_dy (req_step_dy),
      .req_load_x  (req_load_x),
      .req_load_y  (req_load_y),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_pos_x   (rsp_pos_x),
      .rsp_pos_y   (rsp_pos_y),
      .rsp_at_edge (rsp_at_edge)
   );

endmodule

[src/rscv_checker.sv]
module rscv_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [rscv_pkg::POS_W-1:0]        rsp_pos_x,
   input logic [rscv_pkg::POS_W-1:0]        rsp_pos_y,
   input logic                              rsp_at_edge
);

   // a held result must not change under a stall
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x)
         && $stable(rsp_pos_y) && $stable(rsp_at_edge))
      else $error("rsp payload changed while stalled");

   // one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in work");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // a pending result leaves only by a transfer
   a_rsp_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped");

endmodule

bind ray_step_clip_to_viewport_top rscv_checker u_rscv_checker (.*);
